// ----- hw/rtl/sks_pkg.sv -----
// Package with the shared constants, types and codes of the sorted key bound search unit.
`timescale 1ns / 1ps

package sks_pkg;

    localparam int KEYS_MAX = 64;
    localparam int KEY_AW   = $clog2(KEYS_MAX);
    localparam int CNT_W    = $clog2(KEYS_MAX + 1);
    localparam int IDX_W    = CNT_W + 1;
    localparam int KEY_W    = 32;
    localparam int MODE_W   = 3;
    localparam int POS_W    = 8;

    typedef logic signed [KEY_W-1:0]  t_key;
    typedef logic        [KEY_AW-1:0] t_addr;
    typedef logic        [CNT_W-1:0]  t_cnt;
    typedef logic signed [IDX_W-1:0]  t_idx;
    typedef logic signed [POS_W-1:0]  t_pos;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD = 3'd0,
        MODE_LT   = 3'd1,
        MODE_LE   = 3'd2,
        MODE_GE   = 3'd3,
        MODE_GT   = 3'd4,
        MODE_EQ   = 3'd5
    } t_mode;

    typedef struct packed {
        logic  we;
        t_addr waddr;
        t_key  wdata;
        t_addr raddr;
    } t_mem_req;

    typedef struct packed {
        logic lt;
        logic eq;
    } t_cmp_res;

endpackage

// ----- hw/rtl/sks_if.sv -----
// Request and result channel interfaces of the sorted key bound search unit.
`timescale 1ns / 1ps

interface sks_in_if;
    import sks_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [MODE_W-1:0]       mode;
    logic signed [KEY_W-1:0] search_key;
    logic                    last_key;

    modport source (output valid, output mode, output search_key, output last_key,
                     input ready);
    modport sink (input valid, input mode, input search_key, input last_key,
                   output ready);
endinterface

interface sks_out_if;
    import sks_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] position;

    modport source (output valid, output position, input ready);
    modport sink (input valid, input position, output ready);
endinterface

// ----- hw/rtl/sorted_key_bound_search_unit.sv -----
// Top level of the sorted key bound search unit.
//
// The request channel carries a mode, a signed 32-bit key and a last-key flag.
// Mode zero loads the key at the write pointer; a load with the last-key flag
// commits the number of keys written and restarts the pointer. Loads past the
// capacity are dropped. Modes one to five run a lower, upper or exact search
// over the committed keys and send one position on the result channel.
// A load gives no result. A query reads the key store one key at a time: one
// read for the end check (two for exact match), one per midpoint probe (up to 7
// for 64 keys) and one more for the exact match check; the result then moves
// into the output register. The single read port of the key store serializes
// these reads. Request ready is high only while the sequencer is idle.
// A result waits in the output register until the receiver takes it, and a
// new request is accepted meanwhile; a second result waits in the sequencer.
// Synchronous reset clears the key count, the write pointer and the output
// valid; the key store keeps its contents.
`timescale 1ns / 1ps

module sorted_key_bound_search_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sks_in_if.sink    i_req,
    sks_out_if.source o_rsp
);
    import sks_pkg::*;

    t_mem_req w_mem;
    t_key     w_rdata;
    t_key     w_key;
    t_cmp_res w_cmp;

    sks_key_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (w_mem),
        .o_rdata (w_rdata)
    );

    sks_cmp u_cmp (
        .i_data (w_rdata),
        .i_key  (w_key),
        .o_res  (w_cmp)
    );

    sks_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .o_mem   (w_mem),
        .o_key   (w_key),
        .i_cmp   (w_cmp)
    );
endmodule

// ----- hw/rtl/sks_key_mem.sv -----
// Key store memory with one write port and one registered read port.
`timescale 1ns / 1ps

module sks_key_mem (
    input  logic              i_clk,
    input  sks_pkg::t_mem_req i_req,
    output sks_pkg::t_key     o_rdata
);
    import sks_pkg::*;

    t_key r_mem [KEYS_MAX];
    t_key r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hw/rtl/sks_cmp.sv -----
// Shared signed key comparator used by every search step.
`timescale 1ns / 1ps

module sks_cmp (
    input  sks_pkg::t_key     i_data,
    input  sks_pkg::t_key     i_key,
    output sks_pkg::t_cmp_res o_res
);
    import sks_pkg::*;

    always_comb begin
        o_res.lt = (i_data < i_key);
        o_res.eq = (i_data == i_key);
    end
endmodule

// ----- hw/rtl/sks_seq.sv -----
// Sequencer that loads keys and steps the bound searches through the shared comparator.
`timescale 1ns / 1ps

module sks_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sks_in_if.sink            i_req,
    sks_out_if.source         o_rsp,
    output sks_pkg::t_mem_req o_mem,
    output sks_pkg::t_key     o_key,
    input  sks_pkg::t_cmp_res i_cmp
);
    import sks_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE       = 10'b00_0000_0001,
        ST_FIRST_RD   = 10'b00_0000_0010,
        ST_FIRST_CHK  = 10'b00_0000_0100,
        ST_SECOND_RD  = 10'b00_0000_1000,
        ST_SECOND_CHK = 10'b00_0001_0000,
        ST_PROBE_RD   = 10'b00_0010_0000,
        ST_PROBE_CHK  = 10'b00_0100_0000,
        ST_FINAL_RD   = 10'b00_1000_0000,
        ST_FINAL_CHK  = 10'b01_0000_0000,
        ST_DONE       = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;
    t_cnt   r_count, n_count;
    t_cnt   r_wp, n_wp;
    logic   r_out_valid, n_out_valid;
    t_pos   r_out_pos, n_out_pos;
    t_mode  r_mode, n_mode;
    t_key   r_key, n_key;
    t_idx   r_lo, n_lo;
    t_idx   r_hi, n_hi;
    t_idx   r_mid, n_mid;
    t_idx   r_res, n_res;

    logic                    w_accept;
    t_mode                   w_in_mode;
    t_idx                    w_count_idx;
    logic signed [IDX_W:0]   w_sum;
    t_idx                    w_mid;
    logic                    w_right;
    logic                    w_upper;
    t_idx                    w_step_lo;
    t_idx                    w_step_hi;
    t_idx                    w_hi_next;
    logic signed [31:0]      w_res32;
    t_cnt                    w_wp_inc;

    assign w_accept    = i_req.valid && i_req.ready;
    assign w_in_mode   = t_mode'(i_req.mode);
    assign w_count_idx = t_idx'({1'b0, r_count});
    assign w_sum       = {r_lo[IDX_W-1], r_lo} + {r_hi[IDX_W-1], r_hi};
    assign w_mid       = w_sum[IDX_W:1];
    assign w_upper     = (r_mode == MODE_LE) || (r_mode == MODE_GT);
    assign w_right     = i_cmp.lt || (i_cmp.eq && w_upper);
    assign w_step_lo   = w_right ? t_idx'(r_mid + t_idx'(1)) : r_lo;
    assign w_step_hi   = w_right ? r_hi : t_idx'(r_mid - t_idx'(1));
    assign w_hi_next   = t_idx'(r_hi + t_idx'(1));
    assign w_res32     = 32'(r_res);
    assign w_wp_inc    = t_cnt'(r_wp + t_cnt'(1));

    assign i_req.ready    = (r_state == ST_IDLE);
    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.position = r_out_pos;
    assign o_key          = r_key;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_wp        = r_wp;
        n_out_valid = r_out_valid;
        n_out_pos   = r_out_pos;
        n_mode      = r_mode;
        n_key       = r_key;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_res       = r_res;
        o_mem.we    = 1'b0;
        o_mem.waddr = r_wp[KEY_AW-1:0];
        o_mem.wdata = i_req.search_key;
        o_mem.raddr = r_lo[KEY_AW-1:0];

        if (o_rsp.valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (w_in_mode)
                        MODE_LOAD: begin
                            if (r_wp < t_cnt'(KEYS_MAX)) begin
                                o_mem.we = 1'b1;
                                n_wp     = w_wp_inc;
                            end
                            if (i_req.last_key) begin
                                n_count = n_wp;
                                n_wp    = '0;
                            end
                        end
                        MODE_LT, MODE_LE, MODE_GE, MODE_GT, MODE_EQ: begin
                            n_mode = w_in_mode;
                            n_key  = i_req.search_key;
                            n_lo   = '0;
                            n_hi   = t_idx'(w_count_idx - t_idx'(1));
                            if (r_count == '0) begin
                                n_res   = (w_in_mode == MODE_GE || w_in_mode == MODE_GT) ?
                                          '0 : '1;
                                n_state = ST_DONE;
                            end else begin
                                n_state = ST_FIRST_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FIRST_RD: begin
                o_mem.raddr = (r_mode == MODE_LT || r_mode == MODE_LE) ?
                              r_hi[KEY_AW-1:0] : r_lo[KEY_AW-1:0];
                n_state = ST_FIRST_CHK;
            end
            ST_FIRST_CHK: begin
                n_state = ST_PROBE_RD;
                case (r_mode)
                    MODE_LT, MODE_LE: begin
                        if (w_right) begin
                            n_res   = r_hi;
                            n_state = ST_DONE;
                        end
                    end
                    MODE_GE, MODE_GT: begin
                        if (!w_right) begin
                            n_res   = r_lo;
                            n_state = ST_DONE;
                        end
                    end
                    default: begin
                        if (!i_cmp.lt && !i_cmp.eq) begin
                            n_res   = '1;
                            n_state = ST_DONE;
                        end else begin
                            n_state = ST_SECOND_RD;
                        end
                    end
                endcase
            end
            ST_SECOND_RD: begin
                o_mem.raddr = r_hi[KEY_AW-1:0];
                n_state     = ST_SECOND_CHK;
            end
            ST_SECOND_CHK: begin
                if (i_cmp.lt) begin
                    n_res   = '1;
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_PROBE_RD;
                end
            end
            ST_PROBE_RD: begin
                o_mem.raddr = w_mid[KEY_AW-1:0];
                n_mid       = w_mid;
                n_state     = ST_PROBE_CHK;
            end
            ST_PROBE_CHK: begin
                n_lo = w_step_lo;
                n_hi = w_step_hi;
                if (w_step_hi < w_step_lo) begin
                    n_state = ST_DONE;
                    case (r_mode)
                        MODE_LT, MODE_LE: n_res = t_idx'(w_step_lo - t_idx'(1));
                        MODE_GE, MODE_GT: n_res = t_idx'(w_step_hi + t_idx'(1));
                        default: begin
                            if (t_idx'(w_step_hi + t_idx'(1)) >= w_count_idx) begin
                                n_res = '1;
                            end else begin
                                n_state = ST_FINAL_RD;
                            end
                        end
                    endcase
                end else begin
                    n_state = ST_PROBE_RD;
                end
            end
            ST_FINAL_RD: begin
                o_mem.raddr = w_hi_next[KEY_AW-1:0];
                n_state     = ST_FINAL_CHK;
            end
            ST_FINAL_CHK: begin
                n_res   = i_cmp.eq ? w_hi_next : '1;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_pos   = w_res32[POS_W-1:0];
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_wp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_wp        <= n_wp;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_pos <= n_out_pos;
        r_mode    <= n_mode;
        r_key     <= n_key;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_mid     <= n_mid;
        r_res     <= n_res;
    end
endmodule
